@@ rtl/kpa_pkg.sv @@
// Package for the keyed surface pool: sizes, codes and the command
// and status structs passed between the front end, queue and back end.
// Used by every module of the pool except kpa_ram; depends on nothing.
`default_nettype none

package kpa_pkg;

  // Pool sizing: only slots nameable by a 5-bit index are ever used
  localparam int POOL_SLOTS   = 32;
  localparam int FIELD_SLOTS  = 32;
  localparam int USABLE_SLOTS = (POOL_SLOTS < FIELD_SLOTS) ? POOL_SLOTS : FIELD_SLOTS;
  localparam int SLOT_W       = (USABLE_SLOTS > 1) ? $clog2(USABLE_SLOTS) : 1;
  localparam int CNT_W        = $clog2(USABLE_SLOTS + 1);

  // Field widths
  localparam int IDX_W    = 5;
  localparam int KEY_W    = 48;
  localparam int LIFE_W   = 8;
  localparam int FREED_W  = 6;
  localparam int LEVEL_W  = 8;
  localparam int IN_W     = 56;
  localparam int OUT_W    = 16;

  localparam logic [LIFE_W-1:0]  LIFETIME_RESET = 8'd60;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 8'd255;

  // Input transaction kinds (tuser)
  typedef enum logic [1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_BEGIN   = 2'd2,
    REQ_END     = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_BAD_RELEASE = 2'd2,
    ST_UNDERFLOW   = 2'd3
  } status_t;

  // Work handed from the front end to the back end
  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_RELEASE = 2'd1,
    OP_SWEEP   = 2'd2,
    OP_REPORT  = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    status_t          status;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
    logic             idx_ok;
  } cmd_t;

  // Queue fill status
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ALLOC,
    S_REL_RD,
    S_REL_CHK,
    S_SWEEP,
    S_RESULT
  } bk_state_t;

endpackage

`default_nettype wire

@@ rtl/kpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are not reset.
`default_nettype none

module kpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/kpa_front.sv @@
// Front end: accepts input transactions, builds the key, tracks the
// section nesting level and classifies each item into a back-end command. Uses kpa_pkg.
`default_nettype none

module kpa_front
  import kpa_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [IN_W-1:0] s_tdata,
  input  wire logic [1:0]      s_tuser,
  input  wire q_stat_t         q,
  output logic                 push,
  output cmd_t                 push_cmd
);

  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] level_next;

  logic [15:0]      width_px;
  logic [15:0]      height_px;
  logic [7:0]       tex_format;
  logic [3:0]       mip_level;
  logic [IDX_W-1:0] slot_index;

  assign width_px   = s_tdata[15:0];
  assign height_px  = s_tdata[31:16];
  assign tex_format = s_tdata[39:32];
  assign mip_level  = s_tdata[43:40];
  assign slot_index = s_tdata[48:44];

  assign s_tready = !q.full;
  assign push     = s_tvalid && s_tready;

  // Classify the transaction and work out the section level
  always_comb begin
    push_cmd.key    = {4'd0, mip_level, tex_format, height_px, width_px};
    push_cmd.idx    = slot_index;
    push_cmd.idx_ok = ({1'b0, slot_index} < (IDX_W+1)'(USABLE_SLOTS));
    push_cmd.status = ST_OK;
    push_cmd.op     = OP_REPORT;
    level_next      = level;
    case (req_t'(s_tuser))
      REQ_ACQUIRE: begin
        push_cmd.op = OP_LOOKUP;
      end
      REQ_RELEASE: begin
        push_cmd.op = OP_RELEASE;
      end
      REQ_BEGIN: begin
        if (level != LEVEL_MAX) begin
          level_next = level + LEVEL_W'(1);
        end
      end
      REQ_END: begin
        if (level == '0) begin
          push_cmd.status = ST_UNDERFLOW;
        end else begin
          level_next = level - LEVEL_W'(1);
          // closing the outermost section ages the pool
          if (level == LEVEL_W'(1)) begin
            push_cmd.op = OP_SWEEP;
          end
        end
      end
      default: begin
        push_cmd.op = OP_REPORT;
      end
    endcase
  end

  // Section nesting level
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (push) begin
      level <= level_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/kpa_fifo.sv @@
// Two-entry command queue between the front end and the back end.
// Uses kpa_pkg for the command and status types.
`default_nettype none

module kpa_fifo
  import kpa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output q_stat_t   stat
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign pop_cmd    = entry[rd_ptr];
  assign stat.empty = (count == 2'd0);
  assign stat.full  = (count == 2'd2);

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/kpa_back.sv @@
// Back end: sequencer that scans, allocates, releases and ages the slots,
// holds the slot flags and lives, and drives the output register.
// Uses kpa_pkg and one kpa_ram for the slot keys.
`default_nettype none

module kpa_back
  import kpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [LIFE_W-1:0] lifetime,
  input  wire q_stat_t           q,
  input  wire cmd_t              pop_cmd,
  output logic                   pop,
  output logic                   idle,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [OUT_W-1:0]       m_tdata
);

  bk_state_t state;
  bk_state_t state_next;

  cmd_t              cur;
  logic [CNT_W-1:0]  cnt;
  logic              lag_v;
  logic [SLOT_W-1:0] lag_idx;
  logic              found_v;
  logic [SLOT_W-1:0] found_idx;
  logic              empty_v;
  logic [SLOT_W-1:0] empty_idx;

  logic [USABLE_SLOTS-1:0] slot_valid;
  logic [USABLE_SLOTS-1:0] slot_held;
  logic [LIFE_W-1:0]       slot_life [USABLE_SLOTS];

  logic [IDX_W-1:0]   res_slot;
  logic               res_hit;
  status_t            res_status;
  logic [FREED_W-1:0] freed;

  logic [SLOT_W-1:0] sel;
  logic              sel_valid;
  logic              sel_held;
  logic [LIFE_W-1:0] sel_life;
  logic [LIFE_W-1:0] eff_life;
  logic              scan_done;
  logic              sweep_last;
  logic              out_free;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_raddr;
  logic [KEY_W-1:0]  ram_rdata;

  assign eff_life   = (lifetime == '0) ? LIFE_W'(1) : lifetime;
  assign scan_done  = (cnt == CNT_W'(USABLE_SLOTS)) && !lag_v;
  assign sweep_last = (cnt == CNT_W'(USABLE_SLOTS - 1));
  assign out_free   = !m_tvalid || m_tready;
  assign idle       = (state == S_IDLE);
  assign pop        = idle && !q.empty;

  // One slot pointer for the flag and life arrays
  always_comb begin
    case (state)
      S_REL_CHK: sel = cur.idx[SLOT_W-1:0];
      S_SWEEP:   sel = cnt[SLOT_W-1:0];
      default:   sel = lag_idx;
    endcase
  end

  assign sel_valid = slot_valid[sel];
  assign sel_held  = slot_held[sel];
  assign sel_life  = slot_life[sel];

  // Key store: read the scan pointer or the released slot
  assign ram_raddr = (state == S_SCAN) ? cnt[SLOT_W-1:0] : cur.idx[SLOT_W-1:0];
  assign ram_we    = (state == S_ALLOC) && !found_v && empty_v;

  kpa_ram #(
    .WIDTH (KEY_W),
    .DEPTH (USABLE_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (empty_idx),
    .wdata (cur.key),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!q.empty) begin
          case (pop_cmd.op)
            OP_LOOKUP:  state_next = S_SCAN;
            OP_RELEASE: state_next = S_REL_RD;
            OP_SWEEP:   state_next = S_SWEEP;
            default:    state_next = S_RESULT;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_ALLOC;
        end
      end
      S_ALLOC:   state_next = S_RESULT;
      S_REL_RD:  state_next = S_REL_CHK;
      S_REL_CHK: state_next = S_RESULT;
      S_SWEEP: begin
        if (sweep_last) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers (no reset needed)
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur        <= pop_cmd;
        cnt        <= '0;
        lag_v      <= 1'b0;
        found_v    <= 1'b0;
        empty_v    <= 1'b0;
        freed      <= '0;
        res_slot   <= '0;
        res_hit    <= 1'b0;
        res_status <= pop_cmd.status;
      end
      S_SCAN: begin
        lag_v   <= (cnt < CNT_W'(USABLE_SLOTS));
        lag_idx <= cnt[SLOT_W-1:0];
        if (cnt < CNT_W'(USABLE_SLOTS)) begin
          cnt <= cnt + CNT_W'(1);
        end
        // key data for lag_idx arrives now
        if (lag_v) begin
          if (sel_valid) begin
            if (!found_v && !sel_held && (ram_rdata == cur.key)) begin
              found_v   <= 1'b1;
              found_idx <= lag_idx;
            end
          end else if (!empty_v) begin
            empty_v   <= 1'b1;
            empty_idx <= lag_idx;
          end
        end
      end
      S_ALLOC: begin
        if (found_v) begin
          res_slot <= IDX_W'(found_idx);
          res_hit  <= 1'b1;
        end else if (empty_v) begin
          res_slot <= IDX_W'(empty_idx);
        end else begin
          res_status <= ST_FULL;
        end
      end
      S_REL_CHK: begin
        if (!(cur.idx_ok && sel_valid && sel_held && (ram_rdata == cur.key))) begin
          res_status <= ST_BAD_RELEASE;
        end
      end
      S_SWEEP: begin
        cnt <= cnt + CNT_W'(1);
        if (sel_valid && (sel_life == LIFE_W'(1))) begin
          freed <= freed + FREED_W'(1);
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // Slot flags, lives and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_held  <= '0;
      for (int i = 0; i < USABLE_SLOTS; i++) begin
        slot_life[i] <= '0;
      end
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      case (state)
        S_ALLOC: begin
          if (found_v) begin
            slot_held[found_idx] <= 1'b1;
            slot_life[found_idx] <= '0;
          end else if (empty_v) begin
            slot_valid[empty_idx] <= 1'b1;
            slot_held[empty_idx]  <= 1'b1;
            slot_life[empty_idx]  <= '0;
          end
        end
        S_REL_CHK: begin
          if (cur.idx_ok && sel_valid && sel_held && (ram_rdata == cur.key)) begin
            slot_held[sel] <= 1'b0;
            slot_life[sel] <= eff_life;
          end
        end
        S_SWEEP: begin
          if (sel_valid) begin
            if (sel_life != '0) begin
              slot_life[sel] <= sel_life - LIFE_W'(1);
              if (sel_life == LIFE_W'(1)) begin
                slot_valid[sel] <= 1'b0;
                slot_held[sel]  <= 1'b0;
              end
            end else begin
              // held through the frame: force free
              slot_held[sel] <= 1'b0;
              slot_life[sel] <= eff_life;
            end
          end
        end
        default: begin
          slot_valid <= slot_valid;
        end
      endcase

      // output register: load when free, drop when taken
      if ((state == S_RESULT) && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {2'b00, freed, res_status, res_hit, res_slot};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/keyed_pool_with_aging.sv @@
// Keyed surface pool with frame aging. One result per input transaction.
// A request scans the key RAM one slot per cycle (S_SCAN), then allocates (S_ALLOC);
// a frame-closing end sweeps the slots (S_SWEEP); a release reads and checks the slot
// (S_REL_RD, S_REL_CHK); every item ends in S_RESULT. Items run one at a time and output
// stalls hold them. A 2-entry queue takes new ones meanwhile.
// Reset: slot flags and lives clear at once, lifetime 60, keys undefined.
`default_nettype none

module keyed_pool_with_aging
  import kpa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [LIFE_W-1:0]  cfg_wdata,  // lifetime_frames
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  // width_px[15:0], height_px[31:16], tex_format[39:32], mip_level[43:40],
  // slot_index[48:44], zero fill
  input  wire logic [IN_W-1:0]    s_tdata,
  input  wire logic [1:0]         s_tuser,    // req_type
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  // slot_out[4:0], hit[5], status[7:6], freed_count[13:8], zero fill
  output logic [OUT_W-1:0]        m_tdata
);

  logic [LIFE_W-1:0] lifetime;
  q_stat_t           q;
  logic              push;
  cmd_t              push_cmd;
  logic              pop;
  cmd_t              pop_cmd;
  logic              bk_idle;

  // Lifetime register
  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime <= LIFETIME_RESET;
    end else if (cfg_we) begin
      lifetime <= cfg_wdata;
    end
  end

  kpa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q        (q),
    .push     (push),
    .push_cmd (push_cmd)
  );

  kpa_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .stat     (q)
  );

  kpa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .lifetime (lifetime),
    .q        (q),
    .pop_cmd  (pop_cmd),
    .pop      (pop),
    .idle     (bk_idle),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Checks
  a_reset_no_result: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_pop_starts_work: assert property (@(posedge clk) disable iff (rst)
    pop |=> !bk_idle)
    else $error("back end stayed idle after taking a command");

  a_idle_drains_queue: assert property (@(posedge clk) disable iff (rst)
    (bk_idle && !q.empty) |-> pop)
    else $error("idle back end left a queued command waiting");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q.empty)
    else $error("command taken from an empty queue");

endmodule

`default_nettype wire
